// ===== src/assert_macros.svh =====
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define AST_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/zbsf_pkg.sv =====
package zbsf_pkg;

    typedef enum logic [3:0] {
        S_FILL,
        S_IDLE,
        S_CLIP,
        S_DIV,
        S_STEP,
        S_SPAN,
        S_DRAIN,
        S_READ,
        S_DONE
    } t_state;

    localparam logic [1:0] REQ_SPAN  = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // word index of the material color register
    localparam logic CFG_MATERIAL = 1'b0;

    localparam int QW   = 40;  // step quotient magnitude
    localparam int LW   = 12;  // divider remainder
    localparam int ZW   = 42;  // depth accumulator
    localparam int BW   = 34;  // brightness accumulator
    localparam int Z10W = 46;  // depth times ten

    localparam logic [15:0] DEPTH_MIN    = 16'h8000;
    localparam logic [15:0] MATERIAL_RST = 16'hFFFF;
    localparam logic [30:0] RATE_ONE     = 31'h4000_0000;

endpackage

// ===== src/zbuffer_gouraud_span_fill.sv =====
// span: from input transfer to result a span runs the 40-step divider, then one pixel a cycle
//   through the single memory port pair for each of the L pixels of the clipped span; a span
//   that draws nothing goes from clipping straight to its result
// read and clear (a pass over all STORE_WIDTH*STORE_HEIGHT cells) each give a result too;
//   one item at a time, a result that waits for its transfer holds the next item off
// reset is synchronous, active low; a clearing pass over every cell follows
module zbuffer_gouraud_span_fill #(
    parameter int STORE_WIDTH  = 240,
    parameter int STORE_HEIGHT = 180
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic signed [10:0] i_x,
    input  logic signed [10:0] i_y,
    input  logic signed [10:0] i_span_len,
    input  logic signed [23:0] i_depth_first,
    input  logic signed [23:0] i_depth_last,
    input  logic signed [15:0] i_bright_first,
    input  logic signed [15:0] i_bright_last,
    input  logic [15:0]        i_fill_color,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_pixels_written,
    output logic [15:0]        o_pixel_color,
    output logic signed [15:0] o_pixel_depth
);
    import zbsf_pkg::*;

    localparam int CELLS = STORE_WIDTH * STORE_HEIGHT;
    localparam int AW = $clog2(CELLS);
    localparam logic signed [12:0] W13 = 13'(STORE_WIDTH);
    localparam logic signed [12:0] H13 = 13'(STORE_HEIGHT);

    logic [31:0] mem [CELLS];
    logic [31:0] r_q;

    t_state r_state, n_state;
    logic [15:0] r_material;
    logic [1:0] r_req;
    logic signed [10:0] r_x, r_y, r_len;
    logic signed [23:0] r_d0, r_d1;
    logic signed [15:0] r_b0, r_b1;
    logic [15:0] r_fill;
    logic [AW-1:0] r_addr;
    logic r_rd_ok;
    logic [10:0] r_left;
    logic [5:0] r_dcnt;
    logic [QW-1:0] r_zdv, r_bdv;
    logic [LW-1:0] r_zr, r_br;
    logic r_zneg, r_bneg;
    logic signed [ZW-1:0] r_zacc, r_zstep;
    logic signed [BW-1:0] r_bacc, r_bstep;
    logic r_p1_valid;
    logic [AW-1:0] r_p1_addr;
    logic signed [Z10W-1:0] r_p1_z10;
    logic [15:0] r_p1_nd, r_p1_color;
    logic [7:0] r_count;
    logic r_out_valid;
    logic [7:0] r_o_pw;
    logic [15:0] r_o_col, r_o_dep;

    // clipping
    logic signed [12:0] w_x, w_y, w_l, w_cx, w_cl;
    logic w_vis, w_rd_ok;
    logic [AW-1:0] w_base;
    always_comb begin
        w_x = {{2{r_x[10]}}, r_x};
        w_y = {{2{r_y[10]}}, r_y};
        w_l = {{2{r_len[10]}}, r_len};
        w_cx = w_x;
        w_cl = w_l;
        if (w_x < 13'sd0) begin
            w_cl = w_l + w_x;
            w_cx = '0;
        end
        w_vis = (w_cx < W13) && (w_y >= 13'sd0) && (w_y < H13) && (w_cl >= 13'sd1);
        if (w_cx + w_cl - 13'sd1 >= W13) begin
            w_cl = W13 - w_cx;
        end
        w_rd_ok = (w_x >= 13'sd0) && (w_x < W13) && (w_y >= 13'sd0) && (w_y < H13);
        w_base = AW'(int'(w_y[9:0]) * STORE_WIDTH + int'(w_cx[10:0]));
    end

    // divider operands
    logic signed [24:0] w_zdiff, w_zabs;
    logic signed [16:0] w_bdiff, w_babsd;
    always_comb begin
        w_zdiff = {r_d1[23], r_d1} - {r_d0[23], r_d0};
        w_zabs = w_zdiff[24] ? -w_zdiff : w_zdiff;
        w_bdiff = {r_b1[15], r_b1} - {r_b0[15], r_b0};
        w_babsd = w_bdiff[16] ? -w_bdiff : w_bdiff;
    end

    // one restoring step for each divider
    logic [LW-1:0] w_zt, w_bt, w_dlen;
    logic w_zge, w_bge;
    always_comb begin
        w_dlen = {1'b0, r_left};
        w_zt = {r_zr[LW-2:0], r_zdv[QW-1]};
        w_bt = {r_br[LW-2:0], r_bdv[QW-1]};
        w_zge = w_zt >= w_dlen;
        w_bge = w_bt >= w_dlen;
    end

    // per-pixel values from the accumulators
    logic signed [Z10W-1:0] w_zx, w_z10;
    logic signed [21:0] w_zq;
    logic [15:0] w_nd;
    logic signed [BW-1:0] w_babs;
    logic [30:0] w_rate;
    logic [36:0] w_pr, w_pg, w_pb;
    always_comb begin
        w_zx = Z10W'(r_zacc);
        w_z10 = (w_zx <<< 3) + (w_zx <<< 1);
        w_zq = w_z10[Z10W-1:24];
        if (w_z10[Z10W-1] && (|w_z10[23:0])) begin
            w_zq = w_zq + 22'sd1;
        end
        if (w_zq > 22'sd32767) begin
            w_nd = 16'h7FFF;
        end else if (w_zq < -22'sd32768) begin
            w_nd = DEPTH_MIN;
        end else begin
            w_nd = w_zq[15:0];
        end
        w_babs = r_bacc[BW-1] ? -r_bacc : r_bacc;
        w_rate = (w_babs > BW'(RATE_ONE)) ? RATE_ONE : w_babs[30:0];
        w_pr = 37'(w_rate) * 37'(r_material[15:11]);
        w_pg = 37'(w_rate) * 37'(r_material[10:5]);
        w_pb = 37'(w_rate) * 37'(r_material[4:0]);
    end

    // depth test against the stored word
    logic signed [Z10W-1:0] w_sref;
    logic w_hit;
    always_comb begin
        w_sref = Z10W'($signed({r_q[15:0], 24'h0}));
        w_hit = r_p1_valid && (r_p1_z10 > w_sref);
    end

    logic w_we;
    logic [AW-1:0] w_wa;
    logic [31:0] w_wd;
    always_comb begin
        w_we = 1'b0;
        w_wa = r_p1_addr;
        w_wd = {r_p1_color, r_p1_nd};
        if (r_state == S_FILL) begin
            w_we = 1'b1;
            w_wa = r_addr;
            w_wd = {r_fill, DEPTH_MIN};
        end else if (w_hit) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_q <= mem[r_addr];
    end

    logic w_out_free;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_FILL: begin
                if (r_addr == AW'(CELLS - 1)) begin
                    n_state = (r_req == REQ_CLEAR) ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_CLIP;
            end
            S_CLIP: begin
                case (r_req)
                    REQ_SPAN:  n_state = w_vis ? S_DIV : S_DONE;
                    REQ_CLEAR: n_state = S_FILL;
                    REQ_READ:  n_state = S_READ;
                    default:   n_state = S_DONE;
                endcase
            end
            S_DIV: begin
                if (r_dcnt == 6'(QW - 1)) n_state = S_STEP;
            end
            S_STEP: n_state = S_SPAN;
            S_SPAN: begin
                if (r_left == 11'd1) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_DONE;
            S_READ: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_addr <= '0;
            r_req <= REQ_NONE;
            r_fill <= '0;
            r_material <= MATERIAL_RST;
            r_out_valid <= 1'b0;
            r_p1_valid <= 1'b0;
            r_count <= '0;
            r_dcnt <= '0;
            r_left <= '0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && paddr[2] == CFG_MATERIAL) begin
                r_material <= pwdata[15:0];
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_p1_valid <= (r_state == S_SPAN);
            if (w_hit && r_count != 8'hFF) r_count <= r_count + 8'd1;

            case (r_state)
                S_FILL: begin
                    r_addr <= r_addr + AW'(1);
                end
                S_IDLE: begin
                    r_req <= i_req_type;
                    if (i_in_valid) r_fill <= i_fill_color;
                end
                S_CLIP: begin
                    r_count <= '0;
                    r_dcnt <= '0;
                    r_addr <= (r_req == REQ_CLEAR) ? '0 : w_base;
                    r_rd_ok <= w_rd_ok;
                    r_left <= w_cl[10:0];
                    r_zdv <= {w_zabs[23:0], 16'h0};
                    r_bdv <= {8'h0, w_babsd[15:0], 16'h0};
                    r_zneg <= w_zdiff[24];
                    r_bneg <= w_bdiff[16];
                    r_zr <= '0;
                    r_br <= '0;
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + 6'd1;
                    r_zr <= w_zge ? w_zt - w_dlen : w_zt;
                    r_br <= w_bge ? w_bt - w_dlen : w_bt;
                    r_zdv <= {r_zdv[QW-2:0], w_zge};
                    r_bdv <= {r_bdv[QW-2:0], w_bge};
                end
                S_STEP: begin
                    r_zstep <= r_zneg ? -$signed({2'b0, r_zdv}) : $signed({2'b0, r_zdv});
                    r_bstep <= r_bneg ? -$signed({1'b0, r_bdv[32:0]})
                                      : $signed({1'b0, r_bdv[32:0]});
                    r_zacc <= {{2{r_d0[23]}}, r_d0, 16'h0};
                    r_bacc <= {{2{r_b0[15]}}, r_b0, 16'h0};
                end
                S_SPAN: begin
                    r_p1_addr <= r_addr;
                    r_p1_z10 <= w_z10;
                    r_p1_nd <= w_nd;
                    r_p1_color <= {w_pr[34:30], w_pg[35:30], w_pb[34:30]};
                    r_addr <= r_addr + AW'(1);
                    r_zacc <= r_zacc + r_zstep;
                    r_bacc <= r_bacc + r_bstep;
                    r_left <= r_left - 11'd1;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_o_pw <= (r_req == REQ_SPAN) ? r_count : 8'h0;
                        r_o_col <= (r_req == REQ_READ && r_rd_ok) ? r_q[31:16] : 16'h0;
                        r_o_dep <= (r_req == REQ_READ && r_rd_ok) ? r_q[15:0] : 16'h0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_x <= i_x;
            r_y <= i_y;
            r_len <= i_span_len;
            r_d0 <= i_depth_first;
            r_d1 <= i_depth_last;
            r_b0 <= i_bright_first;
            r_b1 <= i_bright_last;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_pixels_written = r_o_pw;
    assign o_pixel_color = r_o_col;
    assign o_pixel_depth = r_o_dep;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_MATERIAL) ? {16'h0, r_material} : 32'h0;

endmodule

// ===== src/zbsf_checker.sv =====
`include "assert_macros.svh"

module zbsf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [7:0]         o_pixels_written,
    input logic [15:0]        o_pixel_color,
    input logic signed [15:0] o_pixel_depth
);
    // a pending result stays until its transfer
    `AST_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    // one item at a time: busy right after an input transfer
    `AST_NEXT(a_busy_after_take, i_in_valid && o_in_ready, !o_in_ready)
    // a span count never comes with read data
    `AST_IMPLY(a_span_no_pixel, o_out_valid && o_pixels_written != 8'h0,
        o_pixel_color == 16'h0 && o_pixel_depth == 16'sh0)
endmodule

bind zbuffer_gouraud_span_fill zbsf_checker u_zbsf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_pixels_written (o_pixels_written),
    .o_pixel_color    (o_pixel_color),
    .o_pixel_depth    (o_pixel_depth)
);

// ===== bench/zbuffer_gouraud_span_fill_test.sv =====
`timescale 1ns / 1ps

module zbuffer_gouraud_span_fill_test;
    import zbsf_pkg::*;

    localparam int SW = 240;
    localparam int SH = 180;
    localparam int CELLS = SW * SH;
    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_req_type;
    logic signed [10:0] i_x, i_y, i_span_len;
    logic signed [23:0] i_depth_first, i_depth_last;
    logic signed [15:0] i_bright_first, i_bright_last;
    logic [15:0]        i_fill_color;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [7:0]         o_pixels_written;
    logic [15:0]        o_pixel_color;
    logic signed [15:0] o_pixel_depth;

    zbuffer_gouraud_span_fill #(.STORE_WIDTH(SW), .STORE_HEIGHT(SH)) dut (.*);

    typedef struct packed {
        logic [7:0]         written;
        logic [15:0]        color;
        logic signed [15:0] depth;
    } t_pixel_result;

    // shadow of the frame stores
    logic [15:0]        shadow_color [CELLS];
    logic signed [15:0] shadow_depth [CELLS];
    logic [15:0]        shadow_material;
    t_pixel_result      pending_results [$];
    int                 errors;
    longint             cycles;
    bit                 sink_busy;   // receiver stalls only in the random part

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [15:0] shade(logic [15:0] c, longint bacc);
        longint r;
        longint nr, ng, nb;
        r = bacc < 0 ? -bacc : bacc;
        if (r > (64'sd1 <<< 30)) r = 64'sd1 <<< 30;
        nr = (r * longint'(c[15:11])) >>> 30;
        ng = (r * longint'(c[10:5])) >>> 30;
        nb = (r * longint'(c[4:0])) >>> 30;
        return {nr[4:0], ng[5:0], nb[4:0]};
    endfunction

    function automatic t_pixel_result predict_pixels(
        logic [1:0] req, int x, int y, int len, longint d0, longint d1,
        longint b0, longint b1, logic [15:0] fc);
        t_pixel_result res;
        longint zacc, zstep, bacc, bstep, z10, nd;
        int idx, count;
        res = '0;
        count = 0;
        if (req == REQ_SPAN) begin
            if (x < 0) begin
                len += x;
                x = 0;
            end
            if (!(x >= SW || y >= SH || y < 0 || len < 1)) begin
                if (x + len - 1 >= SW) len = SW - x;
                zacc = d0 * 65536;
                zstep = ((d1 - d0) * 65536) / len;
                bacc = b0 * 65536;
                bstep = ((b1 - b0) * 65536) / len;
                for (int i = 0; i < len; i++) begin
                    idx = y * SW + x + i;
                    if (i != 0) begin
                        zacc += zstep;
                        bacc += bstep;
                    end
                    z10 = zacc * 10;
                    if (z10 > longint'(shadow_depth[idx]) * (64'sd1 <<< 24)) begin
                        nd = z10 / (64'sd1 <<< 24);
                        if (nd > 32767) nd = 32767;
                        if (nd < -32768) nd = -32768;
                        shadow_color[idx] = shade(shadow_material, bacc);
                        shadow_depth[idx] = nd[15:0];
                        count++;
                    end
                end
            end
            res.written = count > 255 ? 8'd255 : count[7:0];
        end else if (req == REQ_CLEAR) begin
            for (int i = 0; i < CELLS; i++) begin
                shadow_color[i] = fc;
                shadow_depth[i] = DEPTH_MIN;
            end
        end else if (req == REQ_READ) begin
            if (x >= 0 && x < SW && y >= 0 && y < SH) begin
                res.color = shadow_color[y * SW + x];
                res.depth = shadow_depth[y * SW + x];
            end
        end
        return res;
    endfunction

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_pixel_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_pixels_written !== want.written) begin
                    $error("pixels_written expected %0d actual %0d", want.written,
                           o_pixels_written);
                    errors++;
                end
                if (o_pixel_color !== want.color) begin
                    $error("pixel_color expected %h actual %h", want.color, o_pixel_color);
                    errors++;
                end
                if (o_pixel_depth !== want.depth) begin
                    $error("pixel_depth expected %0d actual %0d", want.depth, o_pixel_depth);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= sink_busy ? ($urandom_range(99) >= 17) : 1'b1;
    end

    // valid stays high after a transfer until the next item or an idle gap replaces it
    task automatic send_item(logic [1:0] req, int x, int y, int len, int d0, int d1,
                             int b0, int b1, logic [15:0] fc, bit may_idle);
        if (may_idle && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < 17) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_x            <= x[10:0];
        i_y            <= y[10:0];
        i_span_len     <= len[10:0];
        i_depth_first  <= d0[23:0];
        i_depth_last   <= d1[23:0];
        i_bright_first <= b0[15:0];
        i_bright_last  <= b1[15:0];
        i_fill_color   <= fc;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(predict_pixels(req, $signed(x[10:0]), $signed(y[10:0]),
            $signed(len[10:0]), $signed(d0[23:0]), $signed(d1[23:0]),
            $signed(b0[15:0]), $signed(b1[15:0]), fc));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic write_material(logic [15:0] value);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {CFG_MATERIAL, 2'b00};
        pwdata  <= {16'h0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_material = value;
    endtask

    task automatic test_directed_spans();
        send_item(REQ_SPAN, 10, 5, 20, 24'h10000, 24'h20000, 16'h4000, 16'h4000, 0, 0);
        send_item(REQ_READ, 10, 5, 0, 0, 0, 0, 0, 0, 0);
        send_item(REQ_READ, 29, 5, 0, 0, 0, 0, 0, 0, 0);
        send_item(REQ_SPAN, -1024, 0, 1023, 8388607, -8388608, 32767, -32768, 0, 0);
        send_item(REQ_SPAN, 0, 179, 1023, -8388608, 8388607, -32768, 32767, 0, 0);
        send_item(REQ_SPAN, 239, 179, 1, 8388607, 8388607, 32767, 32767, 16'hFFFF, 0);
        send_item(REQ_SPAN, 240, 3, 5, 1000, 1000, 100, 100, 0, 0);
        send_item(REQ_SPAN, 3, 180, 5, 1000, 1000, 100, 100, 0, 0);
        send_item(REQ_SPAN, 3, -1, 5, 1000, 1000, 100, 100, 0, 0);
        send_item(REQ_SPAN, 3, 3, 0, 1000, 1000, 100, 100, 0, 0);
        send_item(REQ_SPAN, 3, 3, -1024, 1000, 1000, 100, 100, 0, 0);
        send_item(REQ_SPAN, -5, 3, 5, 1000, 1000, 100, 100, 0, 0);
        send_item(REQ_SPAN, 230, 2, 1023, 0, 500000, -20000, 20000, 0, 0);
        send_item(REQ_NONE, 1, 1, 1, 1, 1, 1, 1, 16'hFFFF, 0);
        send_item(REQ_READ, -1024, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(REQ_READ, 1023, 1023, 0, 0, 0, 0, 0, 0, 0);
        send_item(REQ_READ, 0, -1, 0, 0, 0, 0, 0, 0, 0);
        send_item(REQ_READ, 239, 179, 0, 0, 0, 0, 0, 0, 0);
        send_item(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(REQ_READ, 0, 179, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_clear();
        send_item(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 16'hA5C3, 0);
        send_item(REQ_READ, 100, 100, 0, 0, 0, 0, 0, 0, 0);
        send_item(REQ_SPAN, 0, 100, 240, -100, 100, 0, 16'h7FFF, 0, 0);
        send_item(REQ_READ, 120, 100, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random_traffic(int count);
        int r, len;
        for (int n = 0; n < count; n++) begin
            // idle-free stretch in the middle
            sink_busy = !(n >= count / 3 && n < count / 2);
            r = $urandom_range(99);
            len = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(40);
            if (r < 55)
                send_item(REQ_SPAN, $urandom_range(2047) - 1024 + ($urandom_range(1) ?
                    1024 + $urandom_range(1023) - $urandom_range(1023) : 0) % 2048,
                    ($urandom_range(3) == 0) ? $urandom : $urandom_range(SH - 1),
                    len, $urandom, $urandom, $urandom, $urandom, $urandom, sink_busy);
            else if (r < 93)
                send_item(REQ_READ, ($urandom_range(7) == 0) ? $urandom : $urandom_range(SW - 1),
                    ($urandom_range(7) == 0) ? $urandom : $urandom_range(SH - 1),
                    $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, sink_busy);
            else if (r < 95)
                send_item(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, sink_busy);
            else
                send_item(REQ_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, sink_busy);
        end
        sink_busy = 1'b0;
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        sink_busy = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b1;
        i_req_type = REQ_SPAN;
        {i_x, i_y, i_span_len} = '0;
        {i_depth_first, i_depth_last, i_bright_first, i_bright_last, i_fill_color} = '0;
        shadow_material = MATERIAL_RST;
        for (int i = 0; i < CELLS; i++) begin
            shadow_color[i] = '0;
            shadow_depth[i] = DEPTH_MIN;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_spans();
        write_material(16'h0000);
        test_clear();
        write_material(16'hF81F);
        test_random_traffic(130);
        write_material(16'h07E0);
        test_random_traffic(130);
        write_material(16'hFFFF);
        test_random_traffic(140);

        wait_idle();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/zbsf_pkg.sv
src/zbuffer_gouraud_span_fill.sv
src/zbsf_checker.sv
bench/zbuffer_gouraud_span_fill_test.sv
